[src/cte_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cte_pkg
// Types, codes and field limits shared by the calendar time set editor.
// ----------------------------------------------------------------------------
package cte_pkg;

   localparam logic [1:0] FUNC_TICK = 2'd0;
   localparam logic [1:0] FUNC_KEY  = 2'd1;
   localparam logic [1:0] FUNC_LOAD = 2'd2;

   localparam logic [2:0] KEY_NONE = 3'd0;
   localparam logic [2:0] KEY_MODE = 3'd1;
   localparam logic [2:0] KEY_NEXT = 3'd2;
   localparam logic [2:0] KEY_DOWN = 3'd3;
   localparam logic [2:0] KEY_UP   = 3'd4;

   localparam logic [2:0] FIELD_YEAR    = 3'd0;
   localparam logic [2:0] FIELD_MONTH   = 3'd1;
   localparam logic [2:0] FIELD_DAY     = 3'd2;
   localparam logic [2:0] FIELD_WEEKDAY = 3'd3;
   localparam logic [2:0] FIELD_HOUR    = 3'd4;
   localparam logic [2:0] FIELD_MINUTE  = 3'd5;
   localparam logic [2:0] FIELD_SECOND  = 3'd6;

   localparam logic [6:0] YEAR_MAX    = 7'd99;
   localparam logic [6:0] MONTH_MIN   = 7'd1;
   localparam logic [6:0] MONTH_MAX   = 7'd12;
   localparam logic [6:0] DAY_MIN     = 7'd1;
   localparam logic [6:0] WEEKDAY_MIN = 7'd1;
   localparam logic [6:0] WEEKDAY_MAX = 7'd7;
   localparam logic [6:0] HOUR_MAX    = 7'd23;
   localparam logic [6:0] MINSEC_MAX  = 7'd59;
   localparam logic [6:0] ZERO_MIN    = 7'd0;

   localparam logic [4:0] DAYS_LONG  = 5'd31;
   localparam logic [4:0] DAYS_SHORT = 5'd30;
   localparam logic [4:0] DAYS_LEAP  = 5'd29;
   localparam logic [4:0] DAYS_FEB   = 5'd28;

   localparam logic [9:0] FLASH_RESET = 10'd500;

   typedef struct packed {
      logic [6:0] year;
      logic [3:0] month;
      logic [4:0] day;
      logic [2:0] weekday;
      logic [4:0] hour;
      logic [5:0] minute;
      logic [5:0] second;
   } cal_type;

   typedef struct packed {
      logic [1:0] func;
      logic [2:0] key_code;
      cal_type    load;
   } item_type;

   typedef struct packed {
      logic       set_mode;
      logic [2:0] field_select;
      cal_type    cal;
      logic       blink_on;
      logic       sound_enabled;
      logic       beep;
   } result_type;

   function automatic logic [4:0] day_limit(input logic [3:0] month,
                                            input logic [6:0] year);
      logic [4:0] lim;
      case (month) inside
         4'd4, 4'd6, 4'd9, 4'd11: lim = DAYS_SHORT;
         4'd2:                    lim = (year[1:0] == 2'b00) ? DAYS_LEAP : DAYS_FEB;
         default:                 lim = DAYS_LONG;
      endcase
      return lim;
   endfunction

   function automatic logic [6:0] step_val(input logic [6:0] v, input logic [6:0] lo,
                                           input logic [6:0] hi, input logic up);
      logic [7:0] inc;
      logic [6:0] res;
      inc = {1'b0, v} + 8'd1;
      if (up) begin
         res = (inc > {1'b0, hi}) ? lo : inc[6:0];
      end else begin
         res = (v <= lo) ? hi : v - 7'd1;
      end
      return res;
   endfunction

endpackage

[src/cte_edit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cte_edit
// Steps the selected calendar field up or down with wrapping and day fix-up.
// ----------------------------------------------------------------------------
module cte_edit
   import cte_pkg::*;
(
   input  cal_type    cal,
   input  logic [2:0] field_select,
   input  logic       up,
   output cal_type    cal_edit
);

   logic [6:0] month_step;
   logic [6:0] day_step;
   logic [6:0] weekday_step;
   logic [6:0] hour_step;
   logic [6:0] minute_step;
   logic [6:0] second_step;
   logic [4:0] lim_new;
   logic [4:0] lim_cur;

   assign month_step   = step_val({3'd0, cal.month}, MONTH_MIN, MONTH_MAX, up);
   assign lim_new      = day_limit(month_step[3:0], cal.year);
   assign lim_cur      = day_limit(cal.month, cal.year);
   assign day_step     = step_val({2'd0, cal.day}, DAY_MIN, {2'd0, lim_cur}, up);
   assign weekday_step = step_val({4'd0, cal.weekday}, WEEKDAY_MIN, WEEKDAY_MAX, up);
   assign hour_step    = step_val({2'd0, cal.hour}, ZERO_MIN, HOUR_MAX, up);
   assign minute_step  = step_val({1'b0, cal.minute}, ZERO_MIN, MINSEC_MAX, up);
   assign second_step  = step_val({1'b0, cal.second}, ZERO_MIN, MINSEC_MAX, up);

   always_comb begin
      cal_edit = cal;
      case (field_select)
         FIELD_YEAR: begin
            cal_edit.year = step_val(cal.year, ZERO_MIN, YEAR_MAX, up);
         end
         FIELD_MONTH: begin
            cal_edit.month = month_step[3:0];
            if (cal.day > lim_new) begin
               cal_edit.day = DAY_MIN[4:0];
            end
         end
         FIELD_DAY: begin
            cal_edit.day = day_step[4:0];
         end
         FIELD_WEEKDAY: begin
            cal_edit.weekday = weekday_step[2:0];
         end
         FIELD_HOUR: begin
            cal_edit.hour = hour_step[4:0];
         end
         FIELD_MINUTE: begin
            cal_edit.minute = minute_step[5:0];
         end
         FIELD_SECOND: begin
            cal_edit.second = second_step[5:0];
         end
         default: begin
            cal_edit = cal;
         end
      endcase
   end

endmodule

[src/cte_state.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cte_state
// Editor state registers and the next-state logic for one item.
// ----------------------------------------------------------------------------
module cte_state
   import cte_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       fire,
   input  item_type   item,
   input  logic       cfg_write,
   input  logic [9:0] cfg_data,
   output result_type result
);

   logic       mode_ff, mode_in;
   logic [2:0] select_ff, select_in;
   cal_type    cal_ff, cal_in;
   logic       blink_ff, blink_in;
   logic [9:0] tick_ff, tick_in;
   logic       mute_ff, mute_in;
   logic [9:0] flash_ff;
   logic       beep;
   logic [10:0] tick_sum;
   cal_type    cal_edit;

   assign tick_sum = {1'b0, tick_ff} + 11'd1;

   cte_edit u_edit (
      .cal          (cal_ff),
      .field_select (select_ff),
      .up           (item.key_code == KEY_UP),
      .cal_edit     (cal_edit)
   );

   always_comb begin
      mode_in   = mode_ff;
      select_in = select_ff;
      cal_in    = cal_ff;
      blink_in  = blink_ff;
      tick_in   = tick_ff;
      mute_in   = mute_ff;
      beep      = 1'b0;
      case (item.func)
         FUNC_TICK: begin
            if (tick_sum >= {1'b0, flash_ff}) begin
               tick_in  = '0;
               blink_in = mode_ff ? ~blink_ff : 1'b0;
            end else begin
               tick_in = tick_sum[9:0];
            end
         end
         FUNC_KEY: begin
            if (item.key_code inside {[KEY_MODE:KEY_UP]}) begin
               if (item.key_code == KEY_MODE) begin
                  mode_in = ~mode_ff;
                  if (!mode_ff) begin
                     select_in = FIELD_YEAR;
                  end
               end
               if (mode_in) begin
                  if (item.key_code == KEY_NEXT) begin
                     select_in = (select_ff == FIELD_SECOND) ? FIELD_YEAR
                                                             : select_ff + 3'd1;
                  end
                  if (item.key_code == KEY_UP || item.key_code == KEY_DOWN) begin
                     cal_in = cal_edit;
                  end
               end
               if (item.key_code == KEY_DOWN) begin
                  mute_in = ~mute_ff;
               end
               beep = ~mute_in;
            end
         end
         FUNC_LOAD: begin
            if (!mode_ff) begin
               cal_in = item.load;
            end
         end
         default: begin
            beep = 1'b0;
         end
      endcase
   end

   always_comb begin
      result.set_mode      = mode_in;
      result.field_select  = select_in;
      result.cal           = cal_in;
      result.blink_on      = blink_in;
      result.sound_enabled = ~mute_in;
      result.beep          = beep;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= 1'b0;
         select_ff <= FIELD_YEAR;
         cal_ff    <= '0;
         blink_ff  <= 1'b0;
         tick_ff   <= '0;
         mute_ff   <= 1'b0;
      end else if (fire) begin
         mode_ff   <= mode_in;
         select_ff <= select_in;
         cal_ff    <= cal_in;
         blink_ff  <= blink_in;
         tick_ff   <= tick_in;
         mute_ff   <= mute_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flash_ff <= FLASH_RESET;
      end else if (cfg_write) begin
         flash_ff <= cfg_data;
      end
   end

`ifndef SYNTHESIS
   a_select_range: assert property (@(posedge clock) disable iff (reset)
      select_ff <= FIELD_SECOND)
      else $error("field select out of range");

   a_enter_year: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && $rose(mode_ff)) |-> (select_ff == FIELD_YEAR))
      else $error("entering set mode did not select the year");

   a_show_select: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && !mode_ff && !$past(mode_ff)) |-> $stable(select_ff))
      else $error("field select changed in show mode");
`endif

endmodule

[src/calendar_time_set_editor.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// calendar_time_set_editor
// Key-driven calendar clock editor with an input register and a result
// register around the next-state logic.
// ----------------------------------------------------------------------------
// Usage:
// Items arrive on the req_ channel (valid/stall): a millisecond tick, a key
// event or a time snapshot, selected by req_func. Every item produces exactly
// one result on the rsp_ channel: the mode, selected field, calendar values,
// blink phase, sound enable and a beep flag for key events.
// An item is captured in the input register at acceptance; it updates the state
// and the result register once the result register can advance, from where its
// result is offered on the rsp_ channel. One item per cycle is sustained
// while rsp_stall is low; the single state update stage sets that rate.
// When rsp_stall holds a waiting result, the item in the input register waits
// and req_stall rises only if that register is occupied too.
// The csr_ port writes the blink period at any time it is valid; csr_ready is
// always high. Reset clears the state: show mode, year selected, all calendar
// values zero, sound enabled, blink period 500 ticks, both channels empty.
// ----------------------------------------------------------------------------
module calendar_time_set_editor
   import cte_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_func,
   input  logic [2:0] req_key_code,
   input  logic [6:0] req_load_year,
   input  logic [3:0] req_load_month,
   input  logic [4:0] req_load_day,
   input  logic [2:0] req_load_weekday,
   input  logic [4:0] req_load_hour,
   input  logic [5:0] req_load_minute,
   input  logic [5:0] req_load_second,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_set_mode,
   output logic [2:0] rsp_field_select,
   output logic [6:0] rsp_year_out,
   output logic [3:0] rsp_month_out,
   output logic [4:0] rsp_day_out,
   output logic [2:0] rsp_weekday_out,
   output logic [4:0] rsp_hour_out,
   output logic [5:0] rsp_minute_out,
   output logic [5:0] rsp_second_out,
   output logic       rsp_blink_on,
   output logic       rsp_sound_enabled,
   output logic       rsp_beep,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [9:0] csr_flash_period
);

   logic       in_valid_ff, in_valid_in;
   item_type   in_item_ff;
   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_ff;
   result_type result;
   logic       advance;
   logic       accept;
   logic       fire;

   assign advance   = ~rsp_valid_ff | ~rsp_stall;
   assign req_stall = in_valid_ff & ~advance;
   assign accept    = req_valid & ~req_stall;
   assign fire      = in_valid_ff & advance;
   assign csr_ready = 1'b1;

   cte_state u_state (
      .clock     (clock),
      .reset     (reset),
      .fire      (fire),
      .item      (in_item_ff),
      .cfg_write (csr_valid & csr_ready),
      .cfg_data  (csr_flash_period),
      .result    (result)
   );

   always_comb begin
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
      rsp_valid_in = advance ? in_valid_ff : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_item_ff.func          <= req_func;
         in_item_ff.key_code      <= req_key_code;
         in_item_ff.load.year     <= req_load_year;
         in_item_ff.load.month    <= req_load_month;
         in_item_ff.load.day      <= req_load_day;
         in_item_ff.load.weekday  <= req_load_weekday;
         in_item_ff.load.hour     <= req_load_hour;
         in_item_ff.load.minute   <= req_load_minute;
         in_item_ff.load.second   <= req_load_second;
      end
      if (fire) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_set_mode      = rsp_ff.set_mode;
   assign rsp_field_select  = rsp_ff.field_select;
   assign rsp_year_out      = rsp_ff.cal.year;
   assign rsp_month_out     = rsp_ff.cal.month;
   assign rsp_day_out       = rsp_ff.cal.day;
   assign rsp_weekday_out   = rsp_ff.cal.weekday;
   assign rsp_hour_out      = rsp_ff.cal.hour;
   assign rsp_minute_out    = rsp_ff.cal.minute;
   assign rsp_second_out    = rsp_ff.cal.second;
   assign rsp_blink_on      = rsp_ff.blink_on;
   assign rsp_sound_enabled = rsp_ff.sound_enabled;
   assign rsp_beep          = rsp_ff.beep;

`ifndef SYNTHESIS
   a_beep_sound: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_beep) |-> rsp_sound_enabled)
      else $error("beep flagged while muted");
`endif

endmodule
